// ===== rtl/sal_pkg.sv =====
// Shared types and codes for the sorted linked-list key store.
`timescale 1ns / 1ps

package sal_pkg;

    localparam int KEY_W  = 32;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISSING   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_INS_FREE,
        ST_INS_LINK,
        ST_DEL_FREE,
        ST_DEL_LINK,
        ST_CLEAR,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/sorted_array_linked_list.sv =====
// Sorted signed-key linked list in a slot memory, with a free list of unused slots.
//
// Requests arrive on the s_ channel (s_mode, s_key) with a valid/ready handshake:
// search, insert, delete or clear. Every request produces exactly one result
// transaction on the m_ channel (m_status, m_position, m_size).
// Keys and links live in two synchronous memories (one read port, one write
// port, registered read data). A request walks the links from the head,
// one link per cycle, to the first key that is not smaller than s_key.
// When the walk stops, an insert or a delete writes back up to two links, and
// then the result is loaded into the output register. A clear rewrites the
// links one slot per cycle before its result is loaded.
// One request is in flight at a time. s_ready is high whenever the sequencer
// is idle, also while a previous result still waits on m_ready; a stalled
// receiver only holds the sequencer in its final step.
// Reset (aresetn low, synchronous) empties the list, then the block rebuilds
// the free-list links with s_ready low.
// Accesses never overlap on one entry: every read and write is issued from a
// distinct sequencer step, so no forwarding path is needed.
`timescale 1ns / 1ps

module sorted_array_linked_list
    import sal_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [MODE_W-1:0]                 s_mode,
    input  logic signed [KEY_W-1:0]           s_key,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [STAT_W-1:0]                 m_status,
    output logic [$clog2(DEPTH)-1:0]          m_position,
    output logic [$clog2(DEPTH+1)-1:0]        m_size
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] NIL_LINK  = LW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    // Slot memories
    logic signed [KEY_W-1:0] key_mem  [DEPTH];
    logic [LW-1:0]           link_mem [DEPTH];

    state_t                  state_reg, state_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [LW-1:0]           cur_reg, cur_next;
    logic [LW-1:0]           prev_reg, prev_next;
    logic [LW-1:0]           succ_reg, succ_next;
    logic [LW-1:0]           slot_reg, slot_next;
    logic [LW-1:0]           list_head_reg, list_head_next;
    logic [LW-1:0]           free_head_reg, free_head_next;
    logic [LW-1:0]           count_reg, count_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic                    m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]       m_status_reg, m_status_next;
    logic [AW-1:0]           m_pos_reg, m_pos_next;
    logic [LW-1:0]           m_size_reg, m_size_next;

    logic signed [KEY_W-1:0] key_rd_reg;
    logic [LW-1:0]           link_rd_reg;

    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wl_en;
    logic                    wk_en;
    logic [AW-1:0]           wr_addr;
    logic [LW-1:0]           wl_data;

    logic                    cur_ok;
    logic                    prev_ok;
    logic                    advance;
    logic                    found;

    // Walk decisions on the entry just read
    assign cur_ok  = (cur_reg < NIL_LINK);
    assign prev_ok = (prev_reg < NIL_LINK);
    assign advance = cur_ok && (key_rd_reg < key_reg);
    assign found   = cur_ok && (key_rd_reg == key_reg);

    // Memory read port, registered data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            key_rd_reg  <= key_mem[rd_addr];
            link_rd_reg <= link_mem[rd_addr];
        end
    end

    // Memory write port
    always_ff @(posedge aclk) begin
        if (wl_en) begin
            link_mem[wr_addr] <= wl_data;
        end
        if (wk_en) begin
            key_mem[wr_addr] <= key_reg;
        end
    end

    // State and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            list_head_reg <= NIL_LINK;
            free_head_reg <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        succ_reg     <= succ_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        pos_reg      <= pos_next;
        m_status_reg <= m_status_next;
        m_pos_reg    <= m_pos_next;
        m_size_reg   <= m_size_next;
    end

    // Sequencer: next state, memory commands and result
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        succ_next      = succ_reg;
        slot_next      = slot_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_pos_next     = m_pos_reg;
        m_size_next    = m_size_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wl_en          = 1'b0;
        wk_en          = 1'b0;
        wr_addr        = '0;
        wl_data        = '0;
        s_ready        = 1'b0;

        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                // Rebuild the free chain: slot i links to i + 1, last to null
                wl_en    = 1'b1;
                wr_addr  = idx_reg;
                wl_data  = LW'(idx_reg) + LW'(1);
                idx_next = idx_reg + AW'(1);
                if (idx_reg == LAST_SLOT) begin
                    idx_next    = '0;
                    status_next = STAT_OK;
                    pos_next    = '0;
                    state_next  = (state_reg == ST_CLEAR) ? ST_FINISH : ST_IDLE;
                end
            end

            ST_IDLE: begin
                s_ready   = 1'b1;
                mode_next = s_mode;
                key_next  = s_key;
                prev_next = NIL_LINK;
                cur_next  = list_head_reg;
                if (s_valid) begin
                    if (s_mode == MODE_CLEAR) begin
                        list_head_next = NIL_LINK;
                        free_head_next = '0;
                        count_next     = '0;
                        idx_next       = '0;
                        state_next     = ST_CLEAR;
                    end else if (s_mode == MODE_INSERT && free_head_reg >= NIL_LINK) begin
                        status_next = STAT_FULL;
                        pos_next    = '0;
                        state_next  = ST_FINISH;
                    end else begin
                        // Fetch the head entry
                        rd_en      = (list_head_reg < NIL_LINK);
                        rd_addr    = list_head_reg[AW-1:0];
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK: begin
                if (advance) begin
                    // Follow the link, issue the next read at once
                    prev_next = cur_reg;
                    cur_next  = link_rd_reg;
                    rd_en     = (link_rd_reg < NIL_LINK);
                    rd_addr   = link_rd_reg[AW-1:0];
                end else begin
                    if (!cur_ok) begin
                        cur_next = NIL_LINK;
                    end
                    succ_next = link_rd_reg;
                    case (mode_reg)
                        MODE_SEARCH: begin
                            status_next = found ? STAT_OK : STAT_MISSING;
                            pos_next    = found ? cur_reg[AW-1:0] : '0;
                            state_next  = ST_FINISH;
                        end
                        MODE_INSERT: begin
                            if (found) begin
                                status_next = STAT_DUPLICATE;
                                pos_next    = '0;
                                state_next  = ST_FINISH;
                            end else begin
                                // Fetch the link of the first free slot
                                rd_en      = 1'b1;
                                rd_addr    = free_head_reg[AW-1:0];
                                slot_next  = free_head_reg;
                                state_next = ST_INS_FREE;
                            end
                        end
                        MODE_DELETE: begin
                            if (found) begin
                                state_next = ST_DEL_FREE;
                            end else begin
                                status_next = STAT_MISSING;
                                pos_next    = '0;
                                state_next  = ST_FINISH;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_INS_FREE: begin
                // Fill the slot, link it ahead of the stop entry, pop the free list
                wk_en          = 1'b1;
                wl_en          = 1'b1;
                wr_addr        = slot_reg[AW-1:0];
                wl_data        = cur_reg;
                free_head_next = link_rd_reg;
                count_next     = count_reg + LW'(1);
                status_next    = STAT_OK;
                pos_next       = slot_reg[AW-1:0];
                if (prev_ok) begin
                    state_next = ST_INS_LINK;
                end else begin
                    list_head_next = slot_reg;
                    state_next     = ST_FINISH;
                end
            end

            ST_INS_LINK: begin
                wl_en      = 1'b1;
                wr_addr    = prev_reg[AW-1:0];
                wl_data    = slot_reg;
                state_next = ST_FINISH;
            end

            ST_DEL_FREE: begin
                // Push the freed slot on the free list
                wl_en          = 1'b1;
                wr_addr        = cur_reg[AW-1:0];
                wl_data        = free_head_reg;
                free_head_next = cur_reg;
                if (count_reg != '0) begin
                    count_next = count_reg - LW'(1);
                end
                status_next = STAT_OK;
                pos_next    = cur_reg[AW-1:0];
                if (prev_ok) begin
                    state_next = ST_DEL_LINK;
                end else begin
                    list_head_next = succ_reg;
                    state_next     = ST_FINISH;
                end
            end

            ST_DEL_LINK: begin
                wl_en      = 1'b1;
                wr_addr    = prev_reg[AW-1:0];
                wl_data    = succ_reg;
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_pos_next    = pos_reg;
                    m_size_next   = count_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_position = m_pos_reg;
    assign m_size     = m_size_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NIL_LINK)
        else $error("list count exceeds the slot count");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && (wl_en || wk_en)))
        else $error("memory read and write issued in the same cycle");

    a_full_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg == NIL_LINK) == (count_reg == NIL_LINK))
        else $error("free list and list count disagree");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start");

endmodule
